### hdl/integer_to_english_words_macros.svh
// assertion macros for the rtl of integer_to_english_words
// no dependencies; each macro expects clk and rst_n in scope
`ifndef INTEGER_TO_ENGLISH_WORDS_MACROS_SVH
`define INTEGER_TO_ENGLISH_WORDS_MACROS_SVH

// same-cycle implication, disabled while in reset
`define I2EW_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("i2ew: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define I2EW_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("i2ew: next-cycle check failed");

`endif

### hdl/i2ew_pkg.sv
// types, word codes and the binary to bcd step for integer_to_english_words
// no dependencies
package i2ew_pkg;

    localparam int MAG_W  = 32;
    localparam int DIGITS = 10;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CONV_W = BCD_W + MAG_W;
    localparam int BITS_PER_STEP = 4;

    localparam logic [5:0] WORD_NEGATIVE  = 6'd0;
    localparam logic [5:0] WORD_TEEN_BASE = 6'd10;
    localparam logic [5:0] WORD_TENS_BASE = 6'd18;
    localparam logic [5:0] WORD_HUNDRED   = 6'd28;
    localparam logic [5:0] WORD_THOUSAND  = 6'd29;
    localparam logic [5:0] WORD_MILLION   = 6'd30;
    localparam logic [5:0] WORD_BILLION   = 6'd31;
    localparam logic [5:0] WORD_ZERO      = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        PH_HDIG,
        PH_HWORD,
        PH_TENS,
        PH_ONES,
        PH_SCALE
    } phase_t;

    // four shift-and-add-3 steps of double dabble on {bcd, binary}
    function automatic logic [CONV_W-1:0] dabble_step(input logic [CONV_W-1:0] v_in);
        logic [CONV_W-1:0] v;
        v = v_in;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                if (v[MAG_W + 4*k +: 4] >= 4'd5)
                begin
                    v[MAG_W + 4*k +: 4] = v[MAG_W + 4*k +: 4] + 4'd3;
                end
            end
            v = {v[CONV_W-2:0], 1'b0};
        end
        return v;
    endfunction

endpackage

### hdl/integer_to_english_words.sv
// integer_to_english_words: reads a signed 32-bit integer as english word codes
// depends on i2ew_pkg and integer_to_english_words_macros.svh
`include "integer_to_english_words_macros.svh"
//
// usage
// - input: drive value and pulse start; the word is taken on a clock edge where
//   start is high and busy is low. busy falls in the cycle that carries the last word
// - output: each word code appears on word with word_valid high for exactly one
//   cycle; last_word marks the final word of the phrase. the receiver cannot
//   stall, so every strobe must be captured when it appears
// - binary to bcd conversion runs first (4 bits a cycle through one
//   shift-and-add-3 unit), then the sequencer walks billion, million, thousand
//   and unit groups at one phase per cycle (5 phases for a nonzero billion,
//   million or thousand group, 4 for a nonzero unit group; an empty group is
//   skipped at its first phase), then a flush state for the last word
// - busy stays high through conversion, emission and flush for a nonzero number
//   and through the flush state alone for zero; a new number is taken only while
//   busy is low, so one phrase is finished before the next number is taken
// - words go out through a one-word holding register so that the final word
//   can be marked without looking ahead; so words of a phrase may have gaps
// - reset: asynchronous, active low; returns to idle and drops any phrase in
//   progress, no strobe is produced while in reset
//
module integer_to_english_words
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    output logic        word_valid,
    output logic [5:0]  word,
    output logic        last_word
);
    import i2ew_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [1:0] group_reg, group_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [CONV_W-1:0] conv_reg, conv_next;
    logic [5:0] pend_word_reg, pend_word_next;
    logic pend_valid_reg, pend_valid_next;
    logic strobe_reg, strobe_next;
    logic [5:0] word_reg, word_next;
    logic last_reg, last_next;

    // digits of the group under the sequencer
    logic [3:0] dig_h, dig_t, dig_o;
    logic grp_nz;
    logic done_step;
    logic new_valid;
    logic [5:0] new_word;
    logic [31:0] mag;

    // magnitude as unsigned, so the most negative value needs no special case
    assign mag = value[31] ? (~value + 32'd1) : value;

    // group digit select: billion group has only a ones digit
    always_comb
    begin
        case (group_reg)
            2'd0:
            begin
                dig_h = 4'd0;
                dig_t = 4'd0;
                dig_o = conv_reg[MAG_W + 36 +: 4];
            end
            2'd1:
            begin
                dig_h = conv_reg[MAG_W + 32 +: 4];
                dig_t = conv_reg[MAG_W + 28 +: 4];
                dig_o = conv_reg[MAG_W + 24 +: 4];
            end
            2'd2:
            begin
                dig_h = conv_reg[MAG_W + 20 +: 4];
                dig_t = conv_reg[MAG_W + 16 +: 4];
                dig_o = conv_reg[MAG_W + 12 +: 4];
            end
            default:
            begin
                dig_h = conv_reg[MAG_W + 8 +: 4];
                dig_t = conv_reg[MAG_W + 4 +: 4];
                dig_o = conv_reg[MAG_W +: 4];
            end
        endcase
    end

    assign grp_nz = (dig_h != 4'd0) || (dig_t != 4'd0) || (dig_o != 4'd0);

    // final sequencer step: unit group finished or found empty
    assign done_step = (group_reg == 2'd3) &&
                       ((phase_reg == PH_ONES) || (phase_reg == PH_HDIG && !grp_nz));

    // word produced by the current phase, if any
    always_comb
    begin
        new_valid = 1'b0;
        new_word  = WORD_ZERO;
        case (phase_reg)
            PH_HDIG:
            begin
                new_valid = (dig_h != 4'd0);
                new_word  = {2'b00, dig_h};
            end
            PH_HWORD:
            begin
                new_valid = (dig_h != 4'd0);
                new_word  = WORD_HUNDRED;
            end
            PH_TENS:
            begin
                if (dig_t == 4'd1)
                begin
                    // teens read as one word
                    new_valid = 1'b1;
                    new_word  = WORD_TEEN_BASE + {2'b00, dig_o};
                end
                else if (dig_t != 4'd0)
                begin
                    new_valid = 1'b1;
                    new_word  = WORD_TENS_BASE + {2'b00, dig_t};
                end
            end
            PH_ONES:
            begin
                new_valid = (dig_t != 4'd1) && (dig_o != 4'd0);
                new_word  = {2'b00, dig_o};
            end
            PH_SCALE:
            begin
                case (group_reg)
                    2'd0:    new_word = WORD_BILLION;
                    2'd1:    new_word = WORD_MILLION;
                    default: new_word = WORD_THOUSAND;
                endcase
                new_valid = (group_reg != 2'd3);
            end
            default:
            begin
                new_valid = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (value == 32'd0) ? ST_FLUSH : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == 3'd7)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (done_step)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next      = phase_reg;
        group_next      = group_reg;
        cnt_next        = cnt_reg;
        conv_next       = conv_reg;
        pend_word_next  = pend_word_reg;
        pend_valid_next = pend_valid_reg;
        strobe_next     = 1'b0;
        word_next       = word_reg;
        last_next       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    conv_next  = {{BCD_W{1'b0}}, mag};
                    cnt_next   = 3'd0;
                    group_next = 2'd0;
                    phase_next = PH_HDIG;
                    if (value == 32'd0)
                    begin
                        pend_word_next  = WORD_ZERO;
                        pend_valid_next = 1'b1;
                    end
                    else
                    begin
                        // leading negative word waits in the holding register
                        pend_word_next  = WORD_NEGATIVE;
                        pend_valid_next = value[31];
                    end
                end
            end
            ST_CONV:
            begin
                conv_next = dabble_step(conv_reg);
                cnt_next  = cnt_reg + 3'd1;
            end
            ST_EMIT:
            begin
                if (new_valid)
                begin
                    strobe_next     = pend_valid_reg;
                    word_next       = pend_word_reg;
                    pend_word_next  = new_word;
                    pend_valid_next = 1'b1;
                end
                // leave a group after its scale word or the unit ones, or at once if empty
                if ((phase_reg == PH_HDIG && !grp_nz) || phase_reg == PH_SCALE ||
                    (phase_reg == PH_ONES && group_reg == 2'd3))
                begin
                    phase_next = PH_HDIG;
                    group_next = group_reg + 2'd1;
                end
                else
                begin
                    case (phase_reg)
                        PH_HDIG:  phase_next = PH_HWORD;
                        PH_HWORD: phase_next = PH_TENS;
                        PH_TENS:  phase_next = PH_ONES;
                        default:  phase_next = PH_SCALE;
                    endcase
                end
            end
            ST_FLUSH:
            begin
                strobe_next     = pend_valid_reg;
                word_next       = pend_word_reg;
                last_next       = 1'b1;
                pend_valid_next = 1'b0;
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_HDIG;
            group_reg      <= 2'd0;
            cnt_reg        <= 3'd0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            group_reg      <= group_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            last_reg       <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        conv_reg      <= conv_next;
        pend_word_reg <= pend_word_next;
        word_reg      <= word_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign word_valid = strobe_reg;
    assign word       = word_reg;
    assign last_word  = last_reg & strobe_reg;

    // checks
    `I2EW_ASSERT_IMP(a_word_range, word_valid, word <= WORD_ZERO)
    `I2EW_ASSERT_IMP(a_last_needs_strobe, last_word, word_valid)
    `I2EW_ASSERT_NXT(a_flush_ends_phrase, state_reg == ST_FLUSH, word_valid && last_word)
    `I2EW_ASSERT_NXT(a_start_sets_busy, start && !busy, busy)
    `I2EW_ASSERT_IMP(a_more_words_busy, word_valid && !last_word, busy)

endmodule

### tb/sv/integer_to_english_words_tb.sv
// testbench for integer_to_english_words: directed and random integers, word stream checked
// against a behavioral speller; depends on i2ew_pkg and the integer_to_english_words rtl
`timescale 1ns / 100ps

module integer_to_english_words_tb;

    import i2ew_pkg::*;

    // one spoken word as it leaves the block
    typedef struct packed {
        logic [5:0] code;
        logic       last;
    } spoken_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] value;
    logic        word_valid;
    logic [5:0]  word;
    logic        last_word;

    // words still owed by the block, oldest first
    spoken_t pending_words[$];
    int      word_errors;
    // when set, the sender puts no gap between input words
    bit      back_to_back;

    integer_to_english_words u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .word_valid (word_valid),
        .word       (word),
        .last_word  (last_word)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // speller: appends the expected word codes of one integer
    // ------------------------------------------------------------------

    function automatic void say(input logic [5:0] code);
        spoken_t w;
        w.code = code;
        w.last = 1'b0;
        pending_words.push_back(w);
    endfunction

    // one group of 1..999; an empty group says nothing
    function automatic void say_group(input int unsigned grp);
        int unsigned hundreds;
        int unsigned rest;
        hundreds = grp / 100;
        rest     = grp % 100;
        if (hundreds != 0)
        begin
            // digit words share their code with the digit
            say(6'(hundreds));
            say(WORD_HUNDRED);
        end
        if (rest != 0)
        begin
            if (rest < 20)
            begin
                // one..nineteen map straight onto their code
                say(6'(rest));
            end
            else
            begin
                // twenty..ninety sit just above the teens
                say(WORD_TENS_BASE + 6'(rest / 10));
                if (rest % 10 != 0)
                begin
                    say(6'(rest % 10));
                end
            end
        end
    endfunction

    function automatic void spell_number(input logic [31:0] v);
        logic [31:0] mag;
        int unsigned grp;
        spoken_t     tail;
        if (v == 32'd0)
        begin
            say(WORD_ZERO);
        end
        else
        begin
            // magnitude as unsigned, so the most negative value needs no special path
            if (v[31])
            begin
                say(WORD_NEGATIVE);
                mag = ~v + 32'd1;
            end
            else
            begin
                mag = v;
            end
            grp = mag / 32'd1000000000;
            if (grp != 0)
            begin
                say_group(grp);
                say(WORD_BILLION);
            end
            mag = mag % 32'd1000000000;
            grp = mag / 32'd1000000;
            if (grp != 0)
            begin
                say_group(grp);
                say(WORD_MILLION);
            end
            mag = mag % 32'd1000000;
            grp = mag / 32'd1000;
            if (grp != 0)
            begin
                say_group(grp);
                say(WORD_THOUSAND);
            end
            say_group(mag % 32'd1000);
        end
        // final word of the phrase carries the end mark
        tail = pending_words.pop_back();
        tail.last = 1'b1;
        pending_words.push_back(tail);
    endfunction

    // ------------------------------------------------------------------
    // sender: one input word per call, changes at the falling edge
    // ------------------------------------------------------------------

    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap != 0)
        begin
            // start drops only when a gap follows, never lowered and raised in one step
            start <= 1'b0;
            value <= $urandom;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        value <= v;
        // busy read at the edge is the value the block sees for this edge
        do @(posedge clk); while (busy);
        spell_number(v);
    endtask

    // ------------------------------------------------------------------
    // checker: every strobe must match the oldest expected word
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        spoken_t exp_w;
        if (rst_n && word_valid)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got code %0d last %0b",
                         $time, word, last_word);
                word_errors++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (word !== exp_w.code)
                begin
                    $display("%0t: word code mismatch, expected %0d, got %0d",
                             $time, exp_w.code, word);
                    word_errors++;
                end
                if (last_word !== exp_w.last)
                begin
                    $display("%0t: last_word mismatch, expected %0b, got %0b",
                             $time, exp_w.last, last_word);
                    word_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero, one, minus one, both ends of the signed range and 999999999
    task automatic test_extremes();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd999999999);
    endtask

    // each scale word alone and groups left empty in the middle
    task automatic test_scales();
        send_value(32'd1000000000);
        send_value(32'd1000000);
        send_value(32'd1000);
        send_value(32'd100);
        send_value(32'd100100100);
        send_value(32'd1001000);
        send_value(32'd2000000001);
        send_value(-32'sd1000001);
    endtask

    // every teen and every tens word, back to back
    task automatic test_teens_and_tens();
        back_to_back = 1'b1;
        send_value(32'd19);
        send_value(32'd20);
        send_value(32'd10010);
        send_value(32'd1011012013);
        send_value(32'd14015016);
        send_value(32'd17018019);
        send_value(32'd20030040);
        send_value(32'd50060070);
        send_value(32'd80090);
        back_to_back = 1'b0;
    endtask

    // digit words one, three, four, six, seven and nine as hundreds and ones, both signs
    task automatic test_digits();
        send_value(32'd123456789);
        send_value(-32'sd987654321);
    endtask

    task automatic test_random(input int count);
        int          kind;
        int          k;
        longint      big;
        longint      digit;
        logic [31:0] v;
        for (int i = 0; i < count; i++)
        begin
            // switch between paced and gapless stretches now and then
            if (i % 40 == 0)
            begin
                back_to_back = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2:
                begin
                    // any 32-bit pattern, mostly billion-sized
                    v = $urandom;
                end
                3:
                begin
                    // unit group only, either sign
                    v = $urandom_range(0, 999);
                    if ($urandom_range(0, 1) != 0)
                    begin
                        v = -v;
                    end
                end
                4:
                begin
                    v = $urandom_range(0, 999999);
                    if ($urandom_range(0, 1) != 0)
                    begin
                        v = -v;
                    end
                end
                5, 6:
                begin
                    // well-formed groups; billion empty a third of the time, each lower group half the time
                    big = longint'($urandom_range(0, 2)) * 1000000000;
                    if ($urandom_range(0, 1) != 0)
                    begin
                        big += longint'($urandom_range(1, 999)) * 1000000;
                    end
                    if ($urandom_range(0, 1) != 0)
                    begin
                        big += longint'($urandom_range(1, 999)) * 1000;
                    end
                    if ($urandom_range(0, 1) != 0)
                    begin
                        big += longint'($urandom_range(1, 999));
                    end
                    if (big > 64'sd2147483648)
                    begin
                        big -= 1000000000;
                    end
                    v = ($urandom_range(0, 1) != 0) ? 32'(-big) : 32'(big);
                end
                7:
                begin
                    // round numbers: one digit and trailing zeros
                    k = $urandom_range(0, 9);
                    digit = (k == 9) ? $urandom_range(1, 2) : $urandom_range(1, 9);
                    big = digit;
                    repeat (k) big *= 10;
                    v = ($urandom_range(0, 1) != 0) ? 32'(-big) : 32'(big);
                end
                8:
                begin
                    // close to zero or to either end of the range
                    case ($urandom_range(0, 2))
                        0: v = 32'h7FFF_FFFF - $urandom_range(0, 20);
                        1: v = 32'h8000_0000 + $urandom_range(0, 20);
                        default: v = $urandom_range(0, 20) - 10;
                    endcase
                end
                default:
                begin
                    // single bit set or cleared
                    k = $urandom_range(0, 31);
                    v = ($urandom_range(0, 1) != 0) ? (32'd1 << k) : ~(32'd1 << k);
                end
            endcase
            send_value(v);
        end
        back_to_back = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int drain;
        rst_n        = 1'b0;
        start        = 1'b0;
        value        = 32'd0;
        word_errors  = 0;
        back_to_back = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_scales();
        test_teens_and_tens();
        test_digits();
        test_random(350);

        @(negedge clk);
        start <= 1'b0;
        // wait for the last phrase, then a tail long enough for stray strobes
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        for (drain = 0; drain < 40; drain++)
        begin
            @(posedge clk);
        end

        if (word_errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #500000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
